>>> design/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Types, codes and date arithmetic shared by the date set adjuster.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam logic REQ_POLL = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  localparam int unsigned MonthMax   = 12;
  localparam int unsigned YearMax    = 99;
  localparam int unsigned CenturyMax = 99;

  typedef enum logic [1:0] {
    ED_NONE  = 2'd0,
    ED_DAY   = 2'd1,
    ED_MONTH = 2'd2,
    ED_YEAR  = 2'd3
  } edit_t;

  typedef struct packed {
    logic       req_type;
    logic       set_pressed;
    logic       up_pressed;
    logic       down_pressed;
    logic [4:0] load_day;
    logic [3:0] load_month;
    logic [6:0] load_year;
  } req_t;

  typedef struct packed {
    logic [4:0] day_out;
    logic [3:0] month_out;
    logic [6:0] year_out;
    logic [6:0] century_out;
    logic [1:0] edit_field;
    logic       commit;
  } res_t;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic [6:0] century;
  } date_t;

  typedef struct packed {
    logic [3:0] month;
    logic [6:0] year;
    logic [6:0] century;
  } my_t;

  // year 00 leaps when the century is a multiple of four
  function automatic logic [4:0] month_len(logic [3:0] m, logic [6:0] y, logic [6:0] c);
    logic leap;
    leap = (y == 7'd0) ? (c[1:0] == 2'd0) : (y[1:0] == 2'd0);
    case (m)
      4'd2:                      month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

  function automatic my_t fix_my(logic signed [5:0] m, logic signed [7:0] y, logic [6:0] c);
    logic signed [7:0] yy;
    my_t r;
    yy = y;
    r.century = c;
    if (m > $signed(6'(MonthMax))) begin
      r.month = 4'd1;
      yy = y + 8'sd1;
    end else if (m < 6'sd1) begin
      r.month = 4'(MonthMax);
      yy = y - 8'sd1;
    end else begin
      r.month = m[3:0];
    end
    if (yy > $signed(8'(YearMax))) begin
      r.year = 7'd0;
      r.century = (c == 7'(CenturyMax)) ? 7'd0 : c + 7'd1;
    end else if (yy < 8'sd0) begin
      r.year = 7'(YearMax);
      r.century = (c == 7'd0) ? 7'(CenturyMax) : c - 7'd1;
    end else begin
      r.year = yy[6:0];
    end
    return r;
  endfunction

  function automatic date_t normalize(logic signed [6:0] d, logic signed [5:0] m,
                                      logic signed [7:0] y, logic [6:0] c);
    my_t a;
    my_t b;
    logic [4:0] len;
    date_t r;
    a = fix_my(m, y, c);
    len = month_len(a.month, a.year, a.century);
    if (d > $signed({2'b00, len})) begin
      b = fix_my($signed({2'b00, a.month}) + 6'sd1, $signed({1'b0, a.year}), a.century);
      r.day = 5'd1;
    end else if (d < 7'sd1) begin
      b = fix_my($signed({2'b00, a.month}) - 6'sd1, $signed({1'b0, a.year}), a.century);
      r.day = month_len(b.month, b.year, b.century);
    end else begin
      b = a;
      r.day = d[4:0];
    end
    r.month = b.month;
    r.year = b.year;
    r.century = b.century;
    return r;
  endfunction

endpackage

>>> design/dsa_req_if.sv
// ----------------------------------------------------------------------------
// dsa_req_if
// Request channel: valid/ready handshake carrying one key poll or load.
// ----------------------------------------------------------------------------
interface dsa_req_if;
  import dsa_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/dsa_res_if.sv
// ----------------------------------------------------------------------------
// dsa_res_if
// Result channel: valid/ready handshake carrying the current date and mode.
// ----------------------------------------------------------------------------
interface dsa_res_if;
  import dsa_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/date_set_adjuster_top.sv
// ----------------------------------------------------------------------------
// date_set_adjuster_top
// Calendar date keeper with a three-key editor and RTC load.
//
// req_ch takes one request per handshake: a key poll (set/up/down levels)
// or a date load from the RTC. res_ch returns exactly one result per
// request: the normalized date, the field under edit and a commit pulse
// that marks the poll which ended an edit.
// A request passes two registers on its way to the result: the input
// register, then the result register, which the date update logic writes
// in the same cycle as the date state. The block takes one request per
// cycle while the receiver does not stall; each request updates the date
// registers as it leaves the input register.
// Reset sets the date to day 1, month 1, year 01, century 20, no edit,
// and empties both registers. When the receiver stalls the result is held,
// the input register still fills, and req_ch.ready drops once both are
// occupied.
// ----------------------------------------------------------------------------
module date_set_adjuster_top (
  input  logic      clk,
  input  logic      rst,
  dsa_req_if.sink   req_ch,
  dsa_res_if.source res_ch
);
  import dsa_pkg::*;

  req_t              s1;
  logic              s1_valid;
  res_t              res;
  logic              res_valid;
  logic              adv;

  logic [4:0]        cur_day;
  logic [3:0]        cur_month;
  logic [6:0]        cur_year;
  logic [6:0]        cur_century;
  edit_t             edit_mode;

  edit_t             edit_mode_next;
  logic              commit_next;
  logic signed [6:0] d_in;
  logic signed [5:0] m_in;
  logic signed [7:0] y_in;
  date_t             date_next;

  assign adv = s1_valid && (!res_valid || res_ch.ready);
  assign req_ch.ready = !s1_valid || adv;
  assign res_ch.valid = res_valid;
  assign res_ch.data = res;

  always_comb begin
    edit_mode_next = edit_mode;
    commit_next = 1'b0;
    d_in = $signed({2'b00, cur_day});
    m_in = $signed({2'b00, cur_month});
    y_in = $signed({1'b0, cur_year});
    if (s1.req_type == REQ_POLL) begin
      if (s1.set_pressed) begin
        edit_mode_next = edit_t'(edit_mode + 2'd1);
        commit_next = (edit_mode_next == ED_NONE);
      end
      case (edit_mode_next)
        ED_DAY:   d_in = d_in + 7'(s1.up_pressed) - 7'(s1.down_pressed);
        ED_MONTH: m_in = m_in + 6'(s1.up_pressed) - 6'(s1.down_pressed);
        ED_YEAR:  y_in = y_in + 8'(s1.up_pressed) - 8'(s1.down_pressed);
        default:  ;
      endcase
    end else if (edit_mode == ED_NONE) begin
      d_in = $signed({2'b00, s1.load_day});
      m_in = (s1.load_month > 4'(MonthMax)) ? 6'(MonthMax) : $signed({2'b00, s1.load_month});
      y_in = (s1.load_year > 7'(YearMax)) ? 8'(YearMax) : $signed({1'b0, s1.load_year});
    end
    date_next = normalize(d_in, m_in, y_in, cur_century);
  end

  always_ff @(posedge clk) begin
    if (req_ch.valid && req_ch.ready) begin
      s1 <= req_ch.data;
    end
    if (adv) begin
      res.day_out <= date_next.day;
      res.month_out <= date_next.month;
      res.year_out <= date_next.year;
      res.century_out <= date_next.century;
      res.edit_field <= edit_mode_next;
      res.commit <= commit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      res_valid <= 1'b0;
      cur_day <= 5'd1;
      cur_month <= 4'd1;
      cur_year <= 7'd1;
      cur_century <= 7'd20;
      edit_mode <= ED_NONE;
    end else begin
      if (req_ch.ready) begin
        s1_valid <= req_ch.valid;
      end
      if (adv) begin
        res_valid <= 1'b1;
        cur_day <= date_next.day;
        cur_month <= date_next.month;
        cur_year <= date_next.year;
        cur_century <= date_next.century;
        edit_mode <= edit_mode_next;
      end else if (res_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_commit_on_exit: assert property (@(posedge clk) disable iff (rst)
    adv && s1.req_type == REQ_POLL && s1.set_pressed && edit_mode == ED_YEAR
    |=> res.commit && edit_mode == ED_NONE)
    else $error("year edit exit did not commit");

  a_load_while_edit: assert property (@(posedge clk) disable iff (rst)
    adv && s1.req_type == REQ_LOAD && edit_mode != ED_NONE
    |=> $stable(cur_day) && $stable(cur_month) && $stable(cur_year) && $stable(cur_century))
    else $error("load changed date during edit");

  a_valid_date: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.day_out >= 5'd1 && res.month_out >= 4'd1
      && res.month_out <= 4'(MonthMax) && res.year_out <= 7'(YearMax)
      && res.century_out <= 7'(CenturyMax))
    else $error("result date out of range");

  a_mode_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(edit_mode))
    else $error("edit mode changed without a request");

endmodule
